// ----- design/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants of the periodic deadline scheduler
// payload structs for the command and result transactions
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned TaskSlotsDefault = 16;
  localparam int unsigned SlotW = 4;
  // most results a single poll may return
  localparam int unsigned ResultCap = 16;

  typedef enum logic {
    MODE_POLL = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_seconds;
    logic [3:0]  slot;
    logic [15:0] own_interval;
    logic [15:0] group_interval;
    logic [15:0] force_interval;
  } cmd_t;

  typedef struct packed {
    logic [3:0] due_slot;
    logic       forced;
    logic       last_of_run;
  } res_t;

  // control handed from the sequencer into the row of cells
  typedef struct packed {
    logic        load;
    logic [5:0]  load_slot;
    logic        latch;
    logic        take;
    logic [5:0]  take_slot;
    logic        resched;
    logic [31:0] now;
  } cell_ctl_t;

endpackage

// ----- design/pds_cell.sv -----
// ----------------------------------------------------------------------------
// pds_cell: one task slot
// holds one slot's state and passes the running oldest-due candidate onward
// ----------------------------------------------------------------------------
module pds_cell #(
  parameter int unsigned IdxW = 4,
  parameter logic [IdxW-1:0] Index = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pds_pkg::cell_ctl_t  ctl_i,
  input  pds_pkg::cmd_t       cmd_i,
  input  logic                cand_vld_i,
  input  logic [31:0]         cand_age_i,
  input  logic [IdxW-1:0]     cand_idx_i,
  input  logic                cand_frc_i,
  output logic                cand_vld_o,
  output logic [31:0]         cand_age_o,
  output logic [IdxW-1:0]     cand_idx_o,
  output logic                cand_frc_o
);

  logic            valid_q, taken_q, due_q;
  logic [31:0]     dl_q, lft_q, age_q;
  logic [15:0]     per_q, fper_q;
  logic            cand_vld_q, cand_frc_q;
  logic [31:0]     cand_age_q;
  logic [IdxW-1:0] cand_idx_q;
  logic            mine, take_me, frc_now, here;
  logic [15:0]     per_sel;
  logic [31:0]     age_now;

  assign mine    = (ctl_i.load_slot == 6'(Index));
  assign take_me = ctl_i.take && (ctl_i.take_slot == 6'(Index));
  assign per_sel = (cmd_i.own_interval != '0) ? cmd_i.own_interval : cmd_i.group_interval;
  assign age_now = ctl_i.now - dl_q;
  assign frc_now = (fper_q != '0) && ((ctl_i.now - lft_q) >= {16'd0, fper_q});

  // pass the older candidate on; ties keep the lower index from upstream
  assign here = due_q && !taken_q && (!cand_vld_i || age_q > cand_age_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      taken_q    <= 1'b0;
      due_q      <= 1'b0;
      cand_vld_q <= 1'b0;
      cand_age_q <= '0;
      cand_idx_q <= '0;
      cand_frc_q <= 1'b0;
    end else begin
      if (ctl_i.load && mine) valid_q <= 1'b1;
      if (ctl_i.latch) begin
        taken_q <= 1'b0;
        due_q   <= valid_q && !age_now[31];
      end else if (take_me) begin
        taken_q <= 1'b1;
      end
      cand_vld_q <= cand_vld_i || here;
      cand_age_q <= here ? age_q : cand_age_i;
      cand_idx_q <= here ? Index : cand_idx_i;
      cand_frc_q <= here ? frc_now : cand_frc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && mine) begin
      per_q  <= (per_sel == '0) ? 16'd1 : per_sel;
      fper_q <= cmd_i.force_interval;
      dl_q   <= cmd_i.now_seconds;
      lft_q  <= '0;
    end else begin
      if (ctl_i.latch) age_q <= age_now;
      if (take_me && frc_now) lft_q <= ctl_i.now;
      if (ctl_i.resched && taken_q) dl_q <= ctl_i.now + {16'd0, per_q};
    end
  end

  assign cand_vld_o = cand_vld_q;
  assign cand_age_o = cand_age_q;
  assign cand_idx_o = cand_idx_q;
  assign cand_frc_o = cand_frc_q;

endmodule

// ----- design/pds_seq.sv -----
// ----------------------------------------------------------------------------
// pds_seq: poll sequencer
// steps one selection per pass through the registered cell chain
// ----------------------------------------------------------------------------
module pds_seq #(
  parameter int unsigned TaskSlots = pds_pkg::TaskSlotsDefault,
  parameter int unsigned IdxW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pds_pkg::cmd_t      cmd_i,
  input  logic               cand_vld_i,
  input  logic [IdxW-1:0]    cand_idx_i,
  input  logic               cand_frc_i,
  output pds_pkg::cell_ctl_t ctl_o,
  output logic               busy_o,
  output logic               strobe_o,
  output pds_pkg::res_t      result_o
);

  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned NresW = $clog2(pds_pkg::ResultCap + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LATCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RESCH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [31:0]     now_q;
  logic [CntW-1:0] cnt_q;
  logic [NresW-1:0] nres_q;
  logic            pend_q;
  logic [IdxW-1:0] pidx_q;
  logic            pfrc_q;
  logic            strobe_q;
  pds_pkg::res_t   result_q;
  logic            accept;
  logic            eval;
  logic            found;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  // a full pass has settled once the counter reaches the row length
  assign eval   = (state_q == ST_SCAN) && (cnt_q == CntW'(TaskSlots));
  assign found  = eval && cand_vld_i && (nres_q < NresW'(pds_pkg::ResultCap));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && cmd_i.mode == pds_pkg::MODE_POLL) state_d = ST_LATCH;
      ST_LATCH: state_d = ST_SCAN;
      ST_SCAN:  if (eval && !found) state_d = ST_RESCH;
      ST_RESCH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.now = now_q;
    ctl_o.load = accept && cmd_i.mode == pds_pkg::MODE_LOAD;
    ctl_o.load_slot = {2'b00, cmd_i.slot};
    ctl_o.latch = (state_q == ST_LATCH);
    ctl_o.take = found;
    ctl_o.take_slot = 6'(cand_idx_i);
    ctl_o.resched = (state_q == ST_RESCH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      nres_q   <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= 1'b0;
      if (state_q == ST_LATCH) begin
        cnt_q  <= '0;
        nres_q <= '0;
        pend_q <= 1'b0;
      end else if (eval) begin
        cnt_q    <= '0;
        strobe_q <= pend_q;
        pend_q   <= found;
        if (found) nres_q <= nres_q + NresW'(1);
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // the held pick leaves once the next pass tells whether it was the last
  always_ff @(posedge clk_i) begin
    if (accept) now_q <= cmd_i.now_seconds;
    if (eval) begin
      result_q.due_slot    <= 4'(pidx_q);
      result_q.forced      <= pfrc_q;
      result_q.last_of_run <= !found;
      if (found) begin
        pidx_q <= cand_idx_i;
        pfrc_q <= cand_frc_i;
      end
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

// ----- design/periodic_deadline_scheduler.sv -----
// a load is taken only while idle and never raises busy
// a poll holds busy until its last result has left;
// each pick waits for a pass along the registered cell row;
// a result leaves one pass after its pick, the last one in the final busy cycle
// a new poll is taken only once busy is low again; the receiver cannot stall
// reset: asynchronous, clears all valid marks; slot payloads stay undefined
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler: top level
// row of slot cells plus a sequencer that emits due slots oldest first
// ----------------------------------------------------------------------------
module periodic_deadline_scheduler #(
  parameter int unsigned TaskSlots = pds_pkg::TaskSlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pds_pkg::cmd_t cmd_i,
  output logic          strobe,
  output pds_pkg::res_t result_o
);

  localparam int unsigned IdxW = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;

  pds_pkg::cell_ctl_t ctl, ctl_in;
  logic              vld [TaskSlots+1];
  logic [31:0]       age [TaskSlots+1];
  logic [IdxW-1:0]   idx [TaskSlots+1];
  logic              frc [TaskSlots+1];

  // out-of-range load slots never match any cell
  always_comb begin
    ctl_in = ctl;
    if (cmd_i.slot >= 4'(TaskSlots) && TaskSlots < 16) ctl_in.load = 1'b0;
  end

  // an empty candidate enters the head of the row every cycle
  assign vld[0] = 1'b0;
  assign age[0] = '0;
  assign idx[0] = '0;
  assign frc[0] = 1'b0;

  // each cell registers the candidate it hands on, one cell per cycle
  for (genvar g = 0; g < TaskSlots; g++) begin : g_cell
    pds_cell #(.IdxW(IdxW), .Index(IdxW'(g))) u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl_in), .cmd_i,
      .cand_vld_i(vld[g]), .cand_age_i(age[g]), .cand_idx_i(idx[g]),
      .cand_frc_i(frc[g]),
      .cand_vld_o(vld[g+1]), .cand_age_o(age[g+1]), .cand_idx_o(idx[g+1]),
      .cand_frc_o(frc[g+1])
    );
  end

  pds_seq #(.TaskSlots(TaskSlots), .IdxW(IdxW)) u_seq (
    .clk_i, .rst_ni, .start_i(start), .cmd_i,
    .cand_vld_i(vld[TaskSlots]), .cand_idx_i(idx[TaskSlots]),
    .cand_frc_i(frc[TaskSlots]),
    .ctl_o(ctl), .busy_o(busy), .strobe_o(strobe), .result_o
  );

endmodule

// ----- design/pds_checker.sv -----
// ----------------------------------------------------------------------------
// pds_checker: port-level checks of the scheduler
// result strobes only appear during a poll
// ----------------------------------------------------------------------------
module pds_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          strobe,
  input pds_pkg::res_t result_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("strobe outside poll");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.last_of_run |=> !strobe) else $error("strobe after last");
  a_load_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !strobe) else $error("strobe from idle");

endmodule

bind periodic_deadline_scheduler pds_checker u_pds_checker (
  .clk_i, .rst_ni, .start, .busy, .strobe, .result_o
);
